FILE: hw/rtl/psu_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
`default_nettype none

package psu_pkg;

  localparam int unsigned BPP_W  = 4;
  localparam int unsigned LINE_W = 14;
  localparam int unsigned CFG_W  = 14;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES      = 1'd1;

  // Filter type codes
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  typedef struct packed {
    logic [7:0] filtered_byte;
    logic [2:0] filter_type;
    logic       first_line;
  } in_t;

  typedef struct packed {
    logic [7:0] recon_byte;
    logic       bad_filter;
    logic       end_of_line;
  } out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/psu_stream_if.sv
// Valid/ready stream channel carrying one payload word per transaction.
`default_nettype none

interface psu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/png_scanline_unfilter.sv
// PNG scanline filter reconstruction (none, sub, up, average, Paeth) top level.
//
//   channel  | direction | payload                                    | handshake
//   ---------+-----------+--------------------------------------------+------------
//   in_i     | sink      | filtered_byte, filter_type, first_line     | valid/ready
//   out_o    | source    | recon_byte, bad_filter, end_of_line        | valid/ready
//   cfg      | write     | cfg_idx_i, cfg_data_i                      | cfg_we_i
//
// One byte per cycle while the output is taken; stage 1 and output are registered.
// Stage 0 reads the line store at the byte position, stage 1 rebuilds the byte
// and writes it back; a same-entry write in the read cycle is forwarded.
// Input stalls only while both stage 1 and the output register hold data and
// the output is not taken. Reset clears position, histories and valid flags,
// sets the configuration to one; line store and data registers are not cleared.
`default_nettype none

module png_scanline_unfilter #(
  parameter int unsigned MAX_LINE_BYTES      = 8192,
  parameter int unsigned MAX_BYTES_PER_PIXEL = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  psu_stream_if.sink                        in_i,
  psu_stream_if.source                      out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [psu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [psu_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int unsigned HW = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
  localparam int unsigned CW = (AW + 1 > psu_pkg::LINE_W) ? AW + 1 : psu_pkg::LINE_W;

  // Configuration registers
  logic [psu_pkg::BPP_W-1:0]  bpp_q;
  logic [psu_pkg::LINE_W-1:0] line_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q        <= psu_pkg::BPP_W'(1);
      line_bytes_q <= psu_pkg::LINE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psu_pkg::CFG_BYTES_PER_PIXEL: bpp_q <= cfg_data_i[psu_pkg::BPP_W-1:0];
        psu_pkg::CFG_LINE_BYTES:      line_bytes_q <= cfg_data_i[psu_pkg::LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic in_fire, s1_fire;
  logic s1_valid_q, out_valid_q;
  psu_pkg::in_t  in_pl;
  psu_pkg::out_t out_pl_q;

  assign in_pl    = in_i.payload;
  assign s1_fire  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;

  // Stage 0: position, clamps and line store read
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] pos_inc, bpp_eff;
  logic          eol0, has_left0;
  logic [HW-1:0] tap0;

  always_comb begin
    bpp_eff = CW'(bpp_q);
    if (bpp_q == '0) begin
      bpp_eff = CW'(1);
    end else if (bpp_eff > CW'(MAX_BYTES_PER_PIXEL)) begin
      bpp_eff = CW'(MAX_BYTES_PER_PIXEL);
    end
    tap0      = HW'(bpp_eff - CW'(1));
    has_left0 = CW'(pos_q) >= bpp_eff;
    pos_inc   = CW'(pos_q) + CW'(1);
    // Zero length acts as one, lengths past the store saturate
    eol0      = (pos_inc >= CW'(line_bytes_q)) || (pos_inc >= CW'(MAX_LINE_BYTES));
    pos_d     = eol0 ? '0 : pos_inc[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_fire) begin
      pos_q <= pos_d;
    end
  end

  // Line store: one read port in stage 0, one write port in stage 1
  logic [7:0] line_store_q [MAX_LINE_BYTES];
  logic [7:0] rd_data_q;
  logic [7:0] fwd_data_q;
  logic       fwd_sel_q;
  logic [AW-1:0] s1_pos_q;
  logic [7:0] recon;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_store_q[s1_pos_q] <= recon;
    end
    if (in_fire) begin
      rd_data_q <= line_store_q[pos_q];
    end
  end

  // Stage 1 registers
  logic [7:0]    s1_x_q;
  logic [2:0]    s1_ft_q;
  logic          s1_first_q, s1_eol_q, s1_has_left_q;
  logic [HW-1:0] s1_tap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q        <= in_pl.filtered_byte;
      s1_ft_q       <= in_pl.filter_type;
      s1_first_q    <= in_pl.first_line;
      s1_pos_q      <= pos_q;
      s1_eol_q      <= eol0;
      s1_has_left_q <= has_left0;
      s1_tap_q      <= tap0;
      // Forward the byte written at the read edge to the same entry
      fwd_sel_q     <= s1_fire && (s1_pos_q == pos_q);
      fwd_data_q    <= recon;
    end
  end

  // Left and up-left histories
  logic [7:0] left_hist_q   [MAX_BYTES_PER_PIXEL];
  logic [7:0] upleft_hist_q [MAX_BYTES_PER_PIXEL];
  logic [7:0] up_b, left_a, upleft_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
        left_hist_q[k]   <= '0;
        upleft_hist_q[k] <= '0;
      end
    end else if (s1_fire) begin
      for (int k = MAX_BYTES_PER_PIXEL - 1; k > 0; k--) begin
        left_hist_q[k]   <= left_hist_q[k-1];
        upleft_hist_q[k] <= upleft_hist_q[k-1];
      end
      left_hist_q[0]   <= recon;
      upleft_hist_q[0] <= up_b;
    end
  end

  // Stage 1: rebuild the byte
  logic [8:0]         avg_sum;
  logic signed [9:0]  d_bc, d_ac;
  logic signed [10:0] d_p;
  logic [10:0]        pa, pb, pc;
  logic [7:0]         pred;
  logic               bad;

  always_comb begin
    up_b     = s1_first_q ? 8'd0 : (fwd_sel_q ? fwd_data_q : rd_data_q);
    left_a   = s1_has_left_q ? left_hist_q[s1_tap_q] : 8'd0;
    upleft_c = (s1_has_left_q && !s1_first_q) ? upleft_hist_q[s1_tap_q] : 8'd0;

    avg_sum = {1'b0, left_a} + {1'b0, up_b};

    // p - a = b - c, p - b = a - c, p - c = a + b - 2c
    d_bc = $signed({2'b00, up_b}) - $signed({2'b00, upleft_c});
    d_ac = $signed({2'b00, left_a}) - $signed({2'b00, upleft_c});
    d_p  = $signed({3'b000, left_a}) + $signed({3'b000, up_b})
         - $signed({2'b00, upleft_c, 1'b0});
    pa = (d_bc < 0) ? 11'(-d_bc) : 11'(d_bc);
    pb = (d_ac < 0) ? 11'(-d_ac) : 11'(d_ac);
    pc = (d_p < 0)  ? 11'(-d_p)  : 11'(d_p);

    bad  = 1'b0;
    pred = 8'd0;
    recon = 8'd0;
    case (s1_ft_q)
      psu_pkg::FILT_NONE:  pred = 8'd0;
      psu_pkg::FILT_SUB:   pred = left_a;
      psu_pkg::FILT_UP:    pred = up_b;
      psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
      psu_pkg::FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = left_a;
        end else if (pb <= pc) begin
          pred = up_b;
        end else begin
          pred = upleft_c;
        end
      end
      default: bad = 1'b1;
    endcase
    if (!bad) begin
      recon = s1_x_q + pred;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_pl_q.recon_byte  <= recon;
      out_pl_q.bad_filter  <= bad;
      out_pl_q.end_of_line <= s1_eol_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_pl_q;

endmodule

`default_nettype wire

FILE: hw/rtl/psu_checker.sv
// Port-level checks for the PNG scanline unfilter, bound to the top level.
`default_nettype none

module psu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] recon_byte_i,
  input wire logic       bad_filter_i,
  input wire logic       end_of_line_i
);

  // Hold a stalled output transaction unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(recon_byte_i)
      && $stable(bad_filter_i) && $stable(end_of_line_i))
  else $error("output transaction changed while stalled");

  // An invalid filter yields a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bad_filter_i |-> recon_byte_i == 8'd0)
  else $error("bad filter with nonzero byte");

  // Input backpressure only comes from a blocked, occupied output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
  else $error("input stalled while output can drain");

  // A stalled input keeps being offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |=> in_valid_i)
  else $error("input valid dropped before acceptance");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .recon_byte_i  (out_o.payload.recon_byte),
  .bad_filter_i  (out_o.payload.bad_filter),
  .end_of_line_i (out_o.payload.end_of_line)
);

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the PNG scanline unfilter: directed, pressure and random tests.
`timescale 1ns / 100ps

module tb_top;
  import psu_pkg::*;

  localparam int MAX_LINE    = 8192;
  localparam int MAX_BPP     = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP   = 40;

  // Filter codes past Paeth are all invalid
  localparam logic [2:0] FILT_BAD_LO = 3'd5;
  localparam logic [2:0] FILT_BAD_HI = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  psu_stream_if #(.payload_t(in_t))  in_ch ();
  psu_stream_if #(.payload_t(out_t)) out_ch ();

  png_scanline_unfilter #(
    .MAX_LINE_BYTES     (MAX_LINE),
    .MAX_BYTES_PER_PIXEL(MAX_BPP)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Unfilter state mirrored from the block
  logic [7:0]        line_mem    [MAX_LINE];
  bit                line_seen   [MAX_LINE];
  logic [7:0]        left_hist   [MAX_BPP];
  logic [7:0]        upleft_hist [MAX_BPP];
  int                cur_pos;
  logic [BPP_W-1:0]  bpp_reg;
  logic [LINE_W-1:0] len_reg;

  out_t recon_queue[$];
  out_t oldest_recon;

  int src_gap_pct;
  int sink_stall_pct;
  int hold_start;
  int hold_left;

  int mismatches;
  int cycle_count;
  int items_sent;
  int results_seen;
  int eol_seen;
  int bad_seen;
  int cfg_writes;
  int input_stalls;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t MISMATCH %s: got %0h want %0h (result %0d)", $time, what, got, want,
               results_seen);
  endtask

  function automatic out_t unfilter_byte(in_t it);
    int bpp, len, pos, up, left, upleft, pred, p, pa, pb, pc, k;
    out_t res;
    bpp = (bpp_reg == 0) ? 1 : ((bpp_reg > MAX_BPP) ? MAX_BPP : int'(bpp_reg));
    len = (len_reg == 0) ? 1 : ((len_reg > MAX_LINE) ? MAX_LINE : int'(len_reg));
    pos = cur_pos;
    up = it.first_line ? 0 : int'(line_mem[pos]);
    left = (pos >= bpp) ? int'(left_hist[bpp-1]) : 0;
    upleft = (pos >= bpp && !it.first_line) ? int'(upleft_hist[bpp-1]) : 0;
    pred = 0;
    res.bad_filter = 1'b0;
    case (it.filter_type)
      FILT_NONE:  pred = 0;
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = (left + up) / 2;
      FILT_PAETH: begin
        p  = left + up - upleft;
        pa = (p > left) ? p - left : left - p;
        pb = (p > up) ? p - up : up - p;
        pc = (p > upleft) ? p - upleft : upleft - p;
        if (pa <= pb && pa <= pc) pred = left;
        else if (pb <= pc) pred = up;
        else pred = upleft;
      end
      default: res.bad_filter = 1'b1;
    endcase
    res.recon_byte = res.bad_filter ? 8'd0 : 8'(int'(it.filtered_byte) + pred);
    line_mem[pos] = res.recon_byte;
    line_seen[pos] = 1'b1;
    for (k = MAX_BPP - 1; k > 0; k--) begin
      left_hist[k] = left_hist[k-1];
      upleft_hist[k] = upleft_hist[k-1];
    end
    left_hist[0] = res.recon_byte;
    upleft_hist[0] = 8'(up);
    res.end_of_line = (pos + 1) >= len;
    cur_pos = res.end_of_line ? 0 : ((pos + 1) % MAX_LINE);
    return res;
  endfunction

  // Drive one byte and hold it until the block takes it
  task automatic send_item(in_t it);
    // never read a line store entry that holds nothing yet
    if (!it.first_line && !line_seen[cur_pos]) it.first_line = 1'b1;
    @(negedge clk_i);
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    recon_queue.push_back(unfilter_byte(it));
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (recon_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_BYTES_PER_PIXEL) bpp_reg = data[BPP_W-1:0];
    else len_reg = data[LINE_W-1:0];
    cfg_writes++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Send whole scanlines; noise mixes in stray filter codes and first-line flags
  task automatic send_image(int n_lines, int noise_pct);
    in_t it;
    logic [2:0] line_ft;
    int l, cut, cnt;
    for (l = 0; l < n_lines; l++) begin
      line_ft = ($urandom_range(19) == 0) ? 3'($urandom_range(FILT_BAD_LO, FILT_BAD_HI))
                                          : 3'($urandom_range(FILT_NONE, FILT_PAETH));
      cut = ($urandom_range(11) == 0 && noise_pct != 0) ? $urandom_range(1, 20) : 0;
      cnt = 0;
      do begin
        it.filtered_byte = pick_byte();
        it.filter_type   = line_ft;
        it.first_line    = (l == 0);
        if ($urandom_range(99) < noise_pct) begin
          it.filter_type = 3'($urandom_range(7));
          it.first_line  = 1'($urandom_range(1));
        end
        send_item(it);
        cnt++;
      end while (cur_pos != 0 && !(cut != 0 && cnt >= cut));
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_start > 0) begin
      hold_left = hold_start - 1;
      hold_start = 0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               recon_queue.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid === 1'b1 && in_ch.ready !== 1'b1) input_stalls++;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (recon_queue.size() == 0) begin
        report_mismatch("result with nothing pending", out_ch.payload, 0);
      end else begin
        oldest_recon = recon_queue.pop_front();
        if (out_ch.payload.recon_byte !== oldest_recon.recon_byte)
          report_mismatch("recon_byte", out_ch.payload.recon_byte, oldest_recon.recon_byte);
        if (out_ch.payload.bad_filter !== oldest_recon.bad_filter)
          report_mismatch("bad_filter", out_ch.payload.bad_filter, oldest_recon.bad_filter);
        if (out_ch.payload.end_of_line !== oldest_recon.end_of_line)
          report_mismatch("end_of_line", out_ch.payload.end_of_line,
                          oldest_recon.end_of_line);
        if (oldest_recon.end_of_line) eol_seen++;
        if (oldest_recon.bad_filter) bad_seen++;
      end
    end
  end

  // One-byte lines under the reset register values
  task automatic test_reset_defaults();
    send_item('{filtered_byte: 8'hFF, filter_type: FILT_NONE, first_line: 1'b1});
    send_item('{filtered_byte: 8'h00, filter_type: FILT_SUB, first_line: 1'b1});
  endtask

  // One three-byte line per filter, then a line of invalid codes
  task automatic test_each_filter();
    logic [7:0] vals [18] = '{8'hFF, 8'h80, 8'h01,  8'hFF, 8'h01, 8'hFF,
                              8'h00, 8'hFF, 8'h7F,  8'hFF, 8'hFF, 8'h80,
                              8'h10, 8'hF0, 8'hFF,  8'hAA, 8'h55, 8'hFF};
    logic [2:0] fts [5] = '{FILT_NONE, FILT_SUB, FILT_UP, FILT_AVG, FILT_PAETH};
    in_t it;
    int l, b;
    src_gap_pct = 0;
    sink_stall_pct = 0;
    wait_idle();
    write_reg(CFG_BYTES_PER_PIXEL, CFG_W'(1));
    write_reg(CFG_LINE_BYTES, CFG_W'(3));
    for (l = 0; l < 6; l++) begin
      for (b = 0; b < 3; b++) begin
        it.filtered_byte = vals[3*l + b];
        it.filter_type   = (l < 5) ? fts[l] : 3'(FILT_BAD_LO + b);
        it.first_line    = (l == 0);
        send_item(it);
      end
    end
  endtask

  task automatic test_register_limits();
    in_t it;
    int b;
    wait_idle();
    // all bits set: pixel width saturates to eight, line length to the maximum
    write_reg(CFG_BYTES_PER_PIXEL, {CFG_W{1'b1}});
    write_reg(CFG_LINE_BYTES, {CFG_W{1'b1}});
    for (b = 0; b < 3; b++) begin
      it = '{filtered_byte: pick_byte(), filter_type: FILT_PAETH, first_line: 1'b0};
      send_item(it);
    end
    wait_idle();
    // shorten the line under the current position: next byte closes the line
    write_reg(CFG_LINE_BYTES, CFG_W'(2));
    send_item('{filtered_byte: 8'h5A, filter_type: FILT_SUB, first_line: 1'b0});
    wait_idle();
    write_reg(CFG_BYTES_PER_PIXEL, '0);
    write_reg(CFG_LINE_BYTES, '0);
    send_item('{filtered_byte: 8'h81, filter_type: FILT_SUB, first_line: 1'b0});
    send_item('{filtered_byte: 8'h7E, filter_type: FILT_AVG, first_line: 1'b0});
  endtask

  // Stall the output long enough to fill the pipeline, then drain before resuming
  task automatic test_backpressure();
    src_gap_pct = 0;
    sink_stall_pct = 0;
    wait_idle();
    write_reg(CFG_BYTES_PER_PIXEL, CFG_W'(3));
    write_reg(CFG_LINE_BYTES, CFG_W'(8));
    hold_start = 60;
    send_image(3, 0);
    wait_idle();
    send_image(1, 0);
  endtask

  task automatic test_random_images();
    int src_pcts  [4] = '{0, 84, 0, 28};
    int sink_pcts [4] = '{0, 0, 84, 28};
    int ph, start_count;
    logic [CFG_W-1:0] data;
    for (ph = 0; ph < 4; ph++) begin
      start_count = items_sent;
      while (items_sent - start_count < 100) begin
        src_gap_pct = 0;
        wait_idle();
        if ($urandom_range(3) != 0) begin
          data = CFG_W'($urandom()) & ~CFG_W'(4'hF);
          case ($urandom_range(9))
            0:       data[3:0] = 4'd0;
            1:       data[3:0] = 4'($urandom_range(MAX_BPP + 1, 15));
            default: data[3:0] = 4'($urandom_range(1, MAX_BPP));
          endcase
          write_reg(CFG_BYTES_PER_PIXEL, data);
        end
        if ($urandom_range(3) != 0) begin
          case ($urandom_range(9))
            0:       data = '0;
            1:       data = CFG_W'($urandom_range(40, 120));
            default: data = CFG_W'($urandom_range(1, 24));
          endcase
          write_reg(CFG_LINE_BYTES, data);
        end
        src_gap_pct = src_pcts[ph];
        sink_stall_pct = sink_pcts[ph];
        send_image($urandom_range(1, 4), 8);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    src_gap_pct   = 0;
    sink_stall_pct = 0;
    hold_start    = 0;
    hold_left     = 0;
    cur_pos       = 0;
    bpp_reg       = BPP_W'(1);
    len_reg       = LINE_W'(1);
    foreach (left_hist[k]) begin
      left_hist[k] = '0;
      upleft_hist[k] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_each_filter();
    test_register_limits();
    test_backpressure();
    test_random_images();

    src_gap_pct = 0;
    sink_stall_pct = 0;
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (recon_queue.size() != 0) report_mismatch("results never arrived", 0,
                                                 recon_queue.size());
    $display("%0d bytes sent, %0d results checked over %0d register writes", items_sent,
             results_seen, cfg_writes);
    $display("%0d lines closed, %0d invalid filter bytes, %0d input stall cycles", eol_seen,
             bad_seen, input_stalls);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
